FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LCG_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LCG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lcg_pkg.sv
package lcg_pkg;

	// Only the low COUNT_WIDTH bits of the step count are honored.
	localparam int COUNT_WIDTH = 32;
	localparam int VAL_W       = 64;
	localparam int STEP_W      = 32;
	localparam int CNT_W       = (COUNT_WIDTH < STEP_W) ? COUNT_WIDTH : STEP_W;
	localparam int BIT_CNT_W   = $clog2(VAL_W);
	localparam int CFG_IDX_W   = 2;

	localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VAL_W - 1);

	localparam logic [VAL_W-1:0] MODULUS_RST    = 64'd2147483647;
	localparam logic [VAL_W-1:0] MULTIPLIER_RST = 64'd1103515245;
	localparam logic [VAL_W-1:0] INCREMENT_RST  = 64'd12345;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODULUS    = 2'd0,
		REG_MULTIPLIER = 2'd1,
		REG_INCREMENT  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [VAL_W-1:0] modulus;
		logic [VAL_W-1:0] multiplier;
		logic [VAL_W-1:0] increment;
	} lcg_cfg_t;

	typedef struct packed {
		logic idle;
		logic done;
	} lcg_stat_t;

endpackage

FILE: rtl/lcg_addmod.sv
// Modular adder: (p + q + cin) mod m, valid when the unreduced sum is below 2m.
module lcg_addmod
	import lcg_pkg::*;
(
	input  logic [VAL_W-1:0] modulus,
	input  logic [VAL_W-1:0] p,
	input  logic [VAL_W-1:0] q,
	input  logic             cin,
	output logic [VAL_W-1:0] sum
);

	logic [VAL_W:0] raw;
	logic [VAL_W:0] diff;

	always_comb begin
		raw  = {1'b0, p} + {1'b0, q} + {{VAL_W{1'b0}}, cin};
		diff = raw - {1'b0, modulus};
		sum  = (raw >= {1'b0, modulus}) ? diff[VAL_W-1:0] : raw[VAL_W-1:0];
	end

endmodule

FILE: rtl/lcg_ctrl.sv
`include "assert_macros.svh"

// Sequencer around the shared modular adder. Runs the seed and coefficient
// reductions, then square-and-multiply over the step count, one modular
// product at a time.
module lcg_ctrl
	import lcg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  lcg_cfg_t         cfg,
	input  logic             start,
	input  logic [VAL_W-1:0] start_value,
	input  logic [STEP_W-1:0] step_count,
	input  logic             res_ready,
	output lcg_stat_t        stat,
	output logic [VAL_W-1:0] result
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LOAD = 7'b0000010,
		ST_RED  = 7'b0000100,
		ST_DBL  = 7'b0001000,
		ST_ACC  = 7'b0010000,
		ST_FIN  = 7'b0100000,
		ST_WB   = 7'b1000000
	} state_t;

	typedef enum logic [2:0] {
		OP_RED_SEED = 3'd0,
		OP_RED_A    = 3'd1,
		OP_RED_B    = 3'd2,
		OP_RB       = 3'd3,
		OP_RA       = 3'd4,
		OP_PB       = 3'd5,
		OP_PA       = 3'd6,
		OP_OUT      = 3'd7
	} op_t;

	state_t               state_q, state_d;
	op_t                  op_q, op_d;
	logic [BIT_CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0]     n_q, n_d;

	logic [VAL_W-1:0] acc_q, acc_d;
	logic [VAL_W-1:0] x_q, x_d;
	logic [VAL_W-1:0] y_q, y_d;
	logic [VAL_W-1:0] r_q, r_d;
	logic [VAL_W-1:0] pa_q, pa_d;
	logic [VAL_W-1:0] pb_q, pb_d;
	logic [VAL_W-1:0] ra_q, ra_d;
	logic [VAL_W-1:0] rb_q, rb_d;

	logic [VAL_W-1:0] q_op;
	logic             cin;
	logic [VAL_W-1:0] sum;
	logic [VAL_W-1:0] x_src;
	logic [VAL_W-1:0] y_src;
	logic [VAL_W-1:0] addend;
	logic             has_add;
	logic [CNT_W-1:0] n_shift;

	// Next operation of the square-and-multiply loop for remaining count n.
	function automatic op_t pick_op(input logic [CNT_W-1:0] n);
		op_t op;
		if (n == '0) begin
			op = OP_OUT;
		end else if (n[0]) begin
			op = OP_RB;
		end else begin
			op = OP_PB;
		end
		return op;
	endfunction

	lcg_addmod u_addmod (
		.modulus(cfg.modulus),
		.p      (acc_q),
		.q      (q_op),
		.cin    (cin),
		.sum    (sum)
	);

	always_comb begin
		x_src = pa_q;
		y_src = pa_q;
		case (op_q)
			OP_RED_A: y_src = cfg.multiplier;
			OP_RED_B: y_src = cfg.increment;
			OP_RB:    y_src = rb_q;
			OP_RA:    y_src = ra_q;
			OP_PB:    y_src = pb_q;
			OP_OUT: begin
				x_src = r_q;
				y_src = ra_q;
			end
			default:  y_src = pa_q;
		endcase
		has_add = (op_q == OP_RB) || (op_q == OP_PB) || (op_q == OP_OUT);
		addend  = (op_q == OP_OUT) ? rb_q : pb_q;
		n_shift = n_q >> 1;
	end

	// Operand selection for the shared adder.
	always_comb begin
		cin = 1'b0;
		case (state_q)
			ST_RED: begin
				q_op = acc_q;
				cin  = y_q[VAL_W-1];
			end
			ST_DBL:  q_op = acc_q;
			ST_ACC:  q_op = y_q[VAL_W-1] ? x_q : '0;
			ST_FIN:  q_op = addend;
			default: q_op = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		cnt_d   = cnt_q;
		n_d     = n_q;
		acc_d   = acc_q;
		x_d     = x_q;
		y_d     = y_q;
		r_d     = r_q;
		pa_d    = pa_q;
		pb_d    = pb_q;
		ra_d    = ra_q;
		rb_d    = rb_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					y_d     = start_value;
					acc_d   = '0;
					cnt_d   = '0;
					n_d     = step_count[CNT_W-1:0];
					op_d    = OP_RED_SEED;
					state_d = ST_RED;
				end
			end
			ST_LOAD: begin
				acc_d = '0;
				cnt_d = '0;
				x_d   = x_src;
				y_d   = y_src;
				if (op_q == OP_RED_A || op_q == OP_RED_B) begin
					state_d = ST_RED;
				end else begin
					state_d = ST_DBL;
				end
			end
			ST_RED: begin
				acc_d = sum;
				y_d   = y_q << 1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == BIT_LAST) begin
					state_d = ST_WB;
				end
			end
			ST_DBL: begin
				acc_d   = sum;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				acc_d = sum;
				y_d   = y_q << 1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == BIT_LAST) begin
					state_d = has_add ? ST_FIN : ST_WB;
				end else begin
					state_d = ST_DBL;
				end
			end
			ST_FIN: begin
				acc_d   = sum;
				state_d = ST_WB;
			end
			ST_WB: begin
				state_d = ST_LOAD;
				case (op_q)
					OP_RED_SEED: begin
						r_d  = acc_q;
						op_d = OP_RED_A;
					end
					OP_RED_A: begin
						pa_d = acc_q;
						op_d = OP_RED_B;
					end
					OP_RED_B: begin
						pb_d = acc_q;
						ra_d = (cfg.modulus == VAL_W'(1)) ? '0 : VAL_W'(1);
						rb_d = '0;
						op_d = pick_op(n_q);
					end
					OP_RB: begin
						rb_d = acc_q;
						op_d = OP_RA;
					end
					OP_RA: begin
						ra_d = acc_q;
						op_d = OP_PB;
					end
					OP_PB: begin
						pb_d = acc_q;
						op_d = OP_PA;
					end
					OP_PA: begin
						pa_d = acc_q;
						n_d  = n_shift;
						op_d = pick_op(n_shift);
					end
					default: begin
						state_d = res_ready ? ST_IDLE : ST_WB;
					end
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_RED_SEED;
			cnt_q   <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			cnt_q   <= cnt_d;
			n_q     <= n_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		x_q   <= x_d;
		y_q   <= y_d;
		r_q   <= r_d;
		pa_q  <= pa_d;
		pb_q  <= pb_d;
		ra_q  <= ra_d;
		rb_q  <= rb_d;
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_WB) && (op_q == OP_OUT) && res_ready;
	assign result    = acc_q;

	`LCG_ASSERT_IMPLY(a_acc_reduced, state_q != ST_IDLE, acc_q < cfg.modulus, "accumulator not below modulus")
	`LCG_ASSERT_IMPLY(a_leave_via_out, $rose(stat.idle), $past(op_q == OP_OUT), "returned to idle before final product")

endmodule

FILE: rtl/lcg_multi_step.sv
// Multi-step linear congruential generator. Each request transaction carries a
// seed and a step count; the block reduces the seed modulo the modulus, applies
// r <- (a*r + b) mod m step_count times (only the low COUNT_WIDTH bits of the
// count are used) and returns the final r in one response transaction. Modulus,
// multiplier and increment are configuration registers (indexes 0, 1, 2) with
// reset values 2147483647, 1103515245 and 12345; a zero written to the modulus
// is ignored, and writes to index 3 do nothing. Configuration writes and new
// requests are taken only while no request is in flight. All arithmetic runs
// through one 64-bit modular adder: a modular product makes two adder passes
// per multiplier bit. The step count is handled by square-and-multiply, so the
// work per request grows with the bit length of the count and its number of set
// bits. The response sits in an output register, so the next request can be
// accepted while it waits to be taken.
`include "assert_macros.svh"

module lcg_multi_step
	import lcg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,

	// Request channel.
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [VAL_W-1:0]     start_value,
	input  logic [STEP_W-1:0]    step_count,

	// Response channel.
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [VAL_W-1:0]     final_value
);

	lcg_cfg_t         cfg_q;
	lcg_stat_t        stat;
	logic [VAL_W-1:0] result;
	logic             start;
	logic             res_ready;
	logic             rsp_valid_q;
	logic [VAL_W-1:0] final_q;

	// The sequencer owns the datapath for a whole request, so both the request
	// and configuration channels are open only while it sits idle.
	assign req_ready = stat.idle;
	assign cfg_ready = stat.idle;
	assign start     = req_valid && req_ready;

	// The sequencer may hand over a result when the response register is
	// empty or is being emptied in this same cycle.
	assign res_ready = !rsp_valid_q || rsp_ready;

	// Configuration registers. A zero modulus would make every reduction
	// meaningless, so such a write leaves the register unchanged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus    <= MODULUS_RST;
			cfg_q.multiplier <= MULTIPLIER_RST;
			cfg_q.increment  <= INCREMENT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODULUS: begin
					if (cfg_data != '0) begin
						cfg_q.modulus <= cfg_data;
					end
				end
				REG_MULTIPLIER: cfg_q.multiplier <= cfg_data;
				REG_INCREMENT:  cfg_q.increment  <= cfg_data;
				default: ;
			endcase
		end
	end

	lcg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start      (start),
		.start_value(start_value),
		.step_count (step_count),
		.res_ready  (res_ready),
		.stat       (stat),
		.result     (result)
	);

	// Response register: holds one finished result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			final_q <= result;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign final_value = final_q;

	`LCG_ASSERT_NEXT(a_busy_after_req, start, !req_ready, "still ready after accepting a request")
	`LCG_ASSERT_IMPLY(a_no_overwrite, stat.done, !rsp_valid_q || rsp_ready, "result overwrote pending response")

endmodule
